>>> src/bgs_pkg.sv
// ----------------------------------------------------------------------------
// bgs_pkg: shared constants for the bilinear grid sampler
// Field widths, coordinate encoding and default grid geometry.
// ----------------------------------------------------------------------------
package bgs_pkg;

    // Default grid geometry.
    localparam int DEF_INDEX_BITS = 4;
    localparam int DEF_ROW_STRIDE = 19;

    // Field widths fixed by the interface.
    localparam int COORD_BITS  = 12;
    localparam int VALUE_BITS  = 8;
    localparam int SAMPLE_BITS = 13;

    // Coordinate encoding: offset removed, then fraction and cell index fields.
    localparam int COORD_OFFSET = 128;
    localparam int FRAC_LSB     = 3;
    localparam int FRAC_BITS    = 5;
    localparam int INDEX_LSB    = 8;

    // One full weight along one axis, and the width of a weight.
    localparam int WEIGHT_ONE  = 32;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;

    // Action codes.
    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

endpackage

>>> src/bilinear_grid_sampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_core: pipelined bilinear sampler of a byte grid
// Stores a grid of signed bytes and blends four neighbours per sample.
// ----------------------------------------------------------------------------
// Usage:
// The command channel (cmd_valid / cmd_stall) carries one item per transfer.
// A write item (action = 0) stores write_value at write_index and produces no
// result; an address beyond the grid is ignored. A sample item (action = 1)
// returns the blend of the four bytes around row_coord and col_coord, scaled
// by 32, on the result channel (res_valid / res_stall, payload sample_value).
// Five register stages: decode, tap address, grid read, row blend and column
// blend. A sample's result is registered through each of them in that order;
// one item is taken every cycle while the pipeline is not stalled.
// Writes travel the first two stages too and update the grid in the read
// stage, so every sample sees exactly the writes taken before it.
// Each stage holds its item while the stage after it is full and stalled;
// empty stages still fill, so items keep being taken until the pipeline is
// full. Reset clears all valid bits; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_core
    import bgs_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int ROW_STRIDE = DEF_ROW_STRIDE,
    localparam int GRID_DEPTH = ((1 << INDEX_BITS) + 1) * ROW_STRIDE,
    localparam int ADDR_BITS  = $clog2(GRID_DEPTH)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic                          action,
    input  logic [COORD_BITS-1:0]         row_coord,
    input  logic [COORD_BITS-1:0]         col_coord,
    input  logic [ADDR_BITS-1:0]          write_index,
    input  logic signed [VALUE_BITS-1:0]  write_value,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_value
);

    // Derived widths.
    localparam int DIFF_BITS = (INDEX_LSB + INDEX_BITS > COORD_BITS) ?
                               (INDEX_LSB + INDEX_BITS) : COORD_BITS;
    localparam int TAP_MAX   = (1 << INDEX_BITS) * ROW_STRIDE + (1 << INDEX_BITS);
    localparam int TAP_BITS  = $clog2(TAP_MAX + 1);
    localparam int PROD_BITS = VALUE_BITS + WEIGHT_BITS + 1;
    localparam int COL_BITS  = SAMPLE_BITS + WEIGHT_BITS + 1;

    localparam logic [TAP_BITS-1:0]  TAP_DEPTH  = TAP_BITS'(GRID_DEPTH);
    localparam logic [TAP_BITS-1:0]  TAP_STRIDE = TAP_BITS'(ROW_STRIDE);
    localparam logic [ADDR_BITS:0]   WR_DEPTH   = (ADDR_BITS + 1)'(GRID_DEPTH);
    localparam logic [DIFF_BITS-1:0] DIFF_OFFS  = DIFF_BITS'(COORD_OFFSET);
    localparam logic [WEIGHT_BITS-1:0] W_ONE    = WEIGHT_BITS'(WEIGHT_ONE);

    // Grid storage: two copies, both written by every in-range write item.
    logic [VALUE_BITS-1:0] grid_top [GRID_DEPTH];
    logic [VALUE_BITS-1:0] grid_bot [GRID_DEPTH];

    // Stage valid bits and advance conditions.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage payloads.
    logic                   wr1_reg, wr2_reg;
    logic [ADDR_BITS-1:0]   wi1_reg, wi2_reg;
    logic signed [VALUE_BITS-1:0] wv1_reg, wv2_reg;
    logic [INDEX_BITS-1:0]  ri1_reg, ci1_reg;
    logic [FRAC_BITS-1:0]   rf1_reg, cf1_reg;
    logic [TAP_BITS-1:0]    top2_reg;
    logic [FRAC_BITS-1:0]   rf2_reg, cf2_reg;
    logic signed [VALUE_BITS-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [FRAC_BITS-1:0]   rf3_reg, cf3_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic [FRAC_BITS-1:0]   cf4_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // Each stage moves on when it is empty or the next stage moves on.
    assign rdy5 = !v5_reg || !res_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign cmd_stall    = !rdy1;
    assign res_valid    = v5_reg;
    assign sample_value = out_reg;

    // Coordinate decode: remove the offset with wrap, then split the fields.
    logic [DIFF_BITS-1:0] row_diff, col_diff;
    assign row_diff = DIFF_BITS'(row_coord) - DIFF_OFFS;
    assign col_diff = DIFF_BITS'(col_coord) - DIFF_OFFS;

    // Top-left tap address of the cell.
    logic [TAP_BITS-1:0] top_next;
    assign top_next = TAP_BITS'(ri1_reg) * TAP_STRIDE + TAP_BITS'(ci1_reg);

    // Four tap addresses with range checks; an address off the grid reads zero.
    logic [TAP_BITS-1:0]  tap_a0, tap_a1, tap_a2, tap_a3;
    logic                 in0, in1, in2, in3;
    logic [ADDR_BITS-1:0] ad0, ad1, ad2, ad3;
    assign tap_a0 = top2_reg;
    assign tap_a1 = top2_reg + TAP_BITS'(1);
    assign tap_a2 = top2_reg + TAP_STRIDE;
    assign tap_a3 = top2_reg + TAP_STRIDE + TAP_BITS'(1);
    assign in0 = tap_a0 < TAP_DEPTH;
    assign in1 = tap_a1 < TAP_DEPTH;
    assign in2 = tap_a2 < TAP_DEPTH;
    assign in3 = tap_a3 < TAP_DEPTH;
    assign ad0 = in0 ? tap_a0[ADDR_BITS-1:0] : '0;
    assign ad1 = in1 ? tap_a1[ADDR_BITS-1:0] : '0;
    assign ad2 = in2 ? tap_a2[ADDR_BITS-1:0] : '0;
    assign ad3 = in3 ? tap_a3[ADDR_BITS-1:0] : '0;

    // Row blend: weight 32 - f on the upper tap and f on the lower tap.
    logic signed [WEIGHT_BITS:0] rw_hi, rw_lo, cw_lo, cw_hi;
    logic signed [PROD_BITS-1:0] left_wide, right_wide;
    assign rw_lo = signed'({1'b0, WEIGHT_BITS'(rf3_reg)});
    assign rw_hi = signed'({1'b0, W_ONE - WEIGHT_BITS'(rf3_reg)});
    assign left_wide  = PROD_BITS'(t0_reg * rw_hi) + PROD_BITS'(t2_reg * rw_lo);
    assign right_wide = PROD_BITS'(t1_reg * rw_hi) + PROD_BITS'(t3_reg * rw_lo);

    // Column blend, then arithmetic shift right by the fraction width.
    logic signed [COL_BITS-1:0] col_wide;
    assign cw_lo = signed'({1'b0, WEIGHT_BITS'(cf4_reg)});
    assign cw_hi = signed'({1'b0, W_ONE - WEIGHT_BITS'(cf4_reg)});
    assign col_wide = COL_BITS'(left_reg * cw_hi) + COL_BITS'(right_reg * cw_lo);

    // Grid writes and registered tap reads, both as an item enters the read
    // stage, so writes and samples act on the grid in transfer order.
    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg && wr2_reg && ({1'b0, wi2_reg} < WR_DEPTH))
        begin
            grid_top[wi2_reg] <= wv2_reg;
            grid_bot[wi2_reg] <= wv2_reg;
        end
        if (rdy3)
        begin
            t0_reg <= in0 ? signed'(grid_top[ad0]) : '0;
            t1_reg <= in1 ? signed'(grid_top[ad1]) : '0;
            t2_reg <= in2 ? signed'(grid_bot[ad2]) : '0;
            t3_reg <= in3 ? signed'(grid_bot[ad3]) : '0;
        end
    end

    // Valid bits: every item fills the first two stages, and only sample
    // items go on past the read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= cmd_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg && !wr2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Payload registers of the arithmetic stages.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            wr1_reg <= action == ACTION_WRITE;
            wi1_reg <= write_index;
            wv1_reg <= write_value;
            ri1_reg <= row_diff[INDEX_LSB +: INDEX_BITS];
            ci1_reg <= col_diff[INDEX_LSB +: INDEX_BITS];
            rf1_reg <= row_diff[FRAC_LSB +: FRAC_BITS];
            cf1_reg <= col_diff[FRAC_LSB +: FRAC_BITS];
        end
        if (rdy2)
        begin
            wr2_reg  <= wr1_reg;
            wi2_reg  <= wi1_reg;
            wv2_reg  <= wv1_reg;
            top2_reg <= top_next;
            rf2_reg  <= rf1_reg;
            cf2_reg  <= cf1_reg;
        end
        if (rdy3)
        begin
            rf3_reg <= rf2_reg;
            cf3_reg <= cf2_reg;
        end
        if (rdy4)
        begin
            left_reg  <= left_wide[SAMPLE_BITS-1:0];
            right_reg <= right_wide[SAMPLE_BITS-1:0];
            cf4_reg   <= cf3_reg;
        end
        if (rdy5)
        begin
            out_reg <= col_wide[FRAC_BITS +: SAMPLE_BITS];
        end
    end

endmodule

>>> sim/grid_sampler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_sampler_checker: result predictor and comparator for the grid sampler
// Watches both channels of the sampler, keeps its own copy of the height grid,
// works out the blended value of every sample transfer and compares each
// result transfer with the oldest value still outstanding.
// ----------------------------------------------------------------------------
module grid_sampler_checker
    import bgs_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int ROW_STRIDE = DEF_ROW_STRIDE,
    parameter int GRID_DEPTH = ((1 << INDEX_BITS) + 1) * ROW_STRIDE,
    parameter int ADDR_BITS  = $clog2(GRID_DEPTH)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  logic                          action,
    input  logic [COORD_BITS-1:0]         row_coord,
    input  logic [COORD_BITS-1:0]         col_coord,
    input  logic [ADDR_BITS-1:0]          write_index,
    input  logic signed [VALUE_BITS-1:0]  write_value,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    output int                            fail_count,
    output int                            outstanding
);

    // Shadow copy of the grid and the blended values still to come out.
    logic signed [VALUE_BITS-1:0]  height_copy [GRID_DEPTH];
    logic signed [SAMPLE_BITS-1:0] blend_queue [$];

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // One neighbour of the grid; an address past the end reads as zero.
    function automatic int grid_tap(input int addr);
        if (addr >= GRID_DEPTH)
            return 0;
        return int'(height_copy[addr]);
    endfunction

    // Blend the four neighbours of a coordinate pair, keeping a factor of 32.
    function automatic logic signed [SAMPLE_BITS-1:0] blend_sample(
        input logic [COORD_BITS-1:0] rc,
        input logic [COORD_BITS-1:0] cc
    );
        int rd;
        int cd;
        int ri;
        int ci;
        int rf;
        int cf;
        int top;
        int bot;
        int left;
        int right;
        int sum;
        int shifted;
        logic signed [SAMPLE_BITS-1:0] blended;
        // Remove the offset; a coordinate below the offset goes negative, so
        // every index bit above the coordinate width reads as one.
        rd = int'(rc) - COORD_OFFSET;
        cd = int'(cc) - COORD_OFFSET;
        ri = (rd >> INDEX_LSB) & ((1 << INDEX_BITS) - 1);
        ci = (cd >> INDEX_LSB) & ((1 << INDEX_BITS) - 1);
        rf = (rd >> FRAC_LSB) & ((1 << FRAC_BITS) - 1);
        cf = (cd >> FRAC_LSB) & ((1 << FRAC_BITS) - 1);
        top = ri * ROW_STRIDE + ci;
        bot = top + ROW_STRIDE;
        // Blend down the rows first, then across the columns.
        left  = grid_tap(top) * (WEIGHT_ONE - rf) + grid_tap(bot) * rf;
        right = grid_tap(top + 1) * (WEIGHT_ONE - rf) + grid_tap(bot + 1) * rf;
        sum   = left * (WEIGHT_ONE - cf) + right * cf;
        shifted = sum >>> FRAC_BITS;
        blended = shifted[SAMPLE_BITS-1:0];
        return blended;
    endfunction

    // Follow every transfer on both channels.
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [SAMPLE_BITS-1:0] want;
        if (!rst_n)
        begin
            blend_queue.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // Result transfer: compare with the oldest outstanding value.
            if (res_valid && !res_stall)
            begin
                if (blend_queue.size() == 0)
                begin
                    report_mismatch($sformatf("sample_value %0d with no sample outstanding",
                                              sample_value));
                end
                else
                begin
                    want = blend_queue.pop_front();
                    if (sample_value !== want)
                        report_mismatch($sformatf("sample_value %0d, expected %0d",
                                                  sample_value, want));
                end
            end
            // Command transfer: a write updates the grid, a sample is predicted.
            if (cmd_valid && !cmd_stall)
            begin
                if (action == ACTION_WRITE)
                begin
                    if (int'(write_index) < GRID_DEPTH)
                        height_copy[write_index] = write_value;
                end
                else
                begin
                    blend_queue.push_back(blend_sample(row_coord, col_coord));
                end
            end
            outstanding <= blend_queue.size();
        end
    end

endmodule

>>> sim/bilinear_grid_sampler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_core_test: stimulus and verdict for the grid sampler
// Loads the whole grid, runs directed samples at the coordinate and value
// extremes, then a long random mix of writes and samples with random idling
// on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_core_test;
    import bgs_pkg::*;

    localparam int GRID_DEPTH   = ((1 << DEF_INDEX_BITS) + 1) * DEF_ROW_STRIDE;
    localparam int ADDR_BITS    = $clog2(GRID_DEPTH);
    localparam int PERIOD       = 20;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_PERCENT = 30;
    localparam int HOLD_START   = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_stall;
    logic                          action;
    logic [COORD_BITS-1:0]         row_coord;
    logic [COORD_BITS-1:0]         col_coord;
    logic [ADDR_BITS-1:0]          write_index;
    logic signed [VALUE_BITS-1:0]  write_value;
    logic                          res_valid;
    logic                          res_stall;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          calm;
    int                            fail_count;
    int                            outstanding;
    int                            quiet_cycles;

    always #(PERIOD / 2) clk = ~clk;

    bilinear_grid_sampler_core #(
        .INDEX_BITS(DEF_INDEX_BITS),
        .ROW_STRIDE(DEF_ROW_STRIDE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .action(action),
        .row_coord(row_coord),
        .col_coord(col_coord),
        .write_index(write_index),
        .write_value(write_value),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .sample_value(sample_value)
    );

    grid_sampler_checker #(
        .INDEX_BITS(DEF_INDEX_BITS),
        .ROW_STRIDE(DEF_ROW_STRIDE)
    ) sampler_check (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .action(action),
        .row_coord(row_coord),
        .col_coord(col_coord),
        .write_index(write_index),
        .write_value(write_value),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .sample_value(sample_value),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    // Offer one command, with random idle cycles in front, and wait for its
    // transfer. Called and returns at a falling edge.
    task automatic send_item(
        input logic                  act,
        input logic [COORD_BITS-1:0] rc,
        input logic [COORD_BITS-1:0] cc,
        input logic [ADDR_BITS-1:0]  wi,
        input logic [VALUE_BITS-1:0] wv
    );
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid   <= 1'b1;
        action      <= act;
        row_coord   <= rc;
        col_coord   <= cc;
        write_index <= wi;
        write_value <= wv;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_byte(input int addr, input int value);
        send_item(ACTION_WRITE, '0, '0, addr[ADDR_BITS-1:0], value[VALUE_BITS-1:0]);
    endtask

    task automatic sample_at(input logic [COORD_BITS-1:0] rc, input logic [COORD_BITS-1:0] cc);
        send_item(ACTION_SAMPLE, rc, cc, '0, '0);
    endtask

    // Random coordinate, weighted towards the offset, the fraction extremes
    // and the top of the range.
    function automatic logic [COORD_BITS-1:0] pick_coord();
        int u;
        case ($urandom_range(0, 9))
            0: u = $urandom_range(0, COORD_OFFSET - 1);
            1: u = (($urandom_range(0, 15) << INDEX_LSB)
                    | (($urandom_range(0, 1) != 0 ? 31 : 0) << FRAC_LSB)
                    | $urandom_range(0, 7)) + COORD_OFFSET;
            2: u = (1 << COORD_BITS) - 1 - $urandom_range(0, 127);
            default: u = $urandom;
        endcase
        return u[COORD_BITS-1:0];
    endfunction

    // Reset and the main command sequence.
    initial
    begin
        int u;
        int v;
        int last_addr;
        int ri;
        int ci;
        logic [COORD_BITS-1:0] rc;
        logic [COORD_BITS-1:0] cc;

        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        action      = ACTION_WRITE;
        row_coord   = '0;
        col_coord   = '0;
        write_index = '0;
        write_value = '0;
        calm        = 1'b0;
        last_addr   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load every grid byte so that no sample reads an unwritten entry.
        for (int a = 0; a < GRID_DEPTH; a++)
        begin
            v = $urandom;
            send_item(ACTION_WRITE, pick_coord(), pick_coord(), a[ADDR_BITS-1:0],
                      v[VALUE_BITS-1:0]);
        end

        // Full weight on the first corner at both value extremes.
        write_byte(0, -128);
        sample_at(12'h080, 12'h080);
        write_byte(0, 127);
        sample_at(12'h080, 12'h080);
        // A fraction of 15 on one cell with mixed corners.
        write_byte(1, -128);
        write_byte(DEF_ROW_STRIDE, 127);
        write_byte(DEF_ROW_STRIDE + 1, -128);
        sample_at(12'h0f8, 12'h0f8);
        sample_at(12'h0f8, 12'h080);
        sample_at(12'h080, 12'h0f8);
        // Coordinates below the offset wrap to the last cell index.
        sample_at(12'h000, 12'h000);
        sample_at(12'h07f, 12'h07f);
        sample_at(12'h000, 12'hfff);
        sample_at(12'hfff, 12'h000);
        // Top of the coordinate range and the last cell.
        write_byte(GRID_DEPTH - 3, -128);
        sample_at(12'hfff, 12'hfff);
        sample_at(12'hf80, 12'hf80);
        sample_at(12'hf7f, 12'hf7f);
        sample_at(12'h880, 12'h480);
        // Writes past the end of the grid are ignored.
        write_byte(GRID_DEPTH, 5);
        write_byte((1 << ADDR_BITS) - 1, -1);
        sample_at(12'hf80, 12'hf80);

        // Random mix of writes and samples.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm <= (n >= 900 && n < 1200);
            if ($urandom_range(0, 99) < 40)
            begin
                if ($urandom_range(0, 9) == 0)
                    u = $urandom_range(GRID_DEPTH, (1 << ADDR_BITS) - 1);
                else
                    u = $urandom_range(0, GRID_DEPTH - 1);
                v = $urandom;
                last_addr = u;
                send_item(ACTION_WRITE, pick_coord(), pick_coord(), u[ADDR_BITS-1:0],
                          v[VALUE_BITS-1:0]);
            end
            else
            begin
                ri = last_addr / DEF_ROW_STRIDE;
                ci = last_addr % DEF_ROW_STRIDE;
                rc = pick_coord();
                cc = pick_coord();
                // Often aim the sample at the byte just written.
                if ($urandom_range(0, 99) < 25 && ri < (1 << DEF_INDEX_BITS)
                    && ci < (1 << DEF_INDEX_BITS))
                begin
                    u = ((ri << INDEX_LSB) | $urandom_range(0, 255)) + COORD_OFFSET;
                    v = ((ci << INDEX_LSB) | $urandom_range(0, 255)) + COORD_OFFSET;
                    rc = u[COORD_BITS-1:0];
                    cc = v[COORD_BITS-1:0];
                end
                u = $urandom;
                v = $urandom;
                send_item(ACTION_SAMPLE, rc, cc, u[ADDR_BITS-1:0], v[VALUE_BITS-1:0]);
            end
        end
        cmd_valid <= 1'b0;

        // Wait for every sample to come out, then a little longer.
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, one long hold-off and a calm stretch.
    initial
    begin
        int rx_cycle;
        rx_cycle  = 0;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (calm)
            begin
                res_stall <= 1'b0;
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
